// File: sv/vpts_pkg.sv
// ============================================================================
// vpts_pkg: shared types and constants of the vertex projection block
// Number formats, pipeline stage records and the coordinate saturation helper.
// ============================================================================
`default_nettype none

package vpts_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int FRAC_BITS    = 16;
  localparam int ENTRY_WIDTH  = 32;
  localparam int POINT_WIDTH  = 32;
  localparam int OUT_WIDTH    = 32;
  localparam int DIM_WIDTH    = 14;
  localparam int SAT_IN_WIDTH = 64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam logic [1:0] MAT_MODEL = 2'd0;
  localparam logic [1:0] MAT_VIEW  = 2'd1;
  localparam logic [1:0] MAT_PROJ  = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

  localparam coord_t COORD_ONE = coord_t'(1 << FRAC_BITS);
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic       op;
    logic [1:0] sel;
    logic [1:0] row;
    logic [1:0] col;
    entry_t     value;
  } tag_t;

  typedef struct packed {
    logic         valid;
    tag_t         tag;
    coord_t [3:0] vec;
  } xstage_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    coord_t w;
  } clip_t;

  typedef struct packed {
    logic   valid;
    logic   w_zero;
    coord_t x;
    coord_t y;
  } ndc_t;

  typedef struct packed {
    logic                        w_zero;
    logic signed [OUT_WIDTH-1:0] sx;
    logic signed [OUT_WIDTH-1:0] sy;
  } pix_t;

  function automatic coord_t sat_coord(input logic signed [SAT_IN_WIDTH-1:0] v);
    coord_t r;
    if (v > SAT_IN_WIDTH'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < SAT_IN_WIDTH'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/vpts_if.sv
// ============================================================================
// vpts_if: request and result channels of the vertex projection block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
`default_nettype none

interface vpts_in_if;
  import vpts_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [1:0]                    matrix_select;
  logic [1:0]                    row_index;
  logic [1:0]                    col_index;
  logic signed [ENTRY_WIDTH-1:0] entry_value;
  logic signed [POINT_WIDTH-1:0] point_x;
  logic signed [POINT_WIDTH-1:0] point_y;
  logic signed [POINT_WIDTH-1:0] point_z;

  modport source (
    output valid, op, matrix_select, row_index, col_index, entry_value,
           point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, op, matrix_select, row_index, col_index, entry_value,
           point_x, point_y, point_z,
    output ready
  );
endinterface

interface vpts_out_if;
  import vpts_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] screen_x;
  logic signed [OUT_WIDTH-1:0] screen_y;
  logic                        w_was_zero;

  modport source (output valid, screen_x, screen_y, w_was_zero, input ready);
  modport sink   (input valid, screen_x, screen_y, w_was_zero, output ready);
endinterface

`default_nettype wire

// File: sv/vpts_xform.sv
// ============================================================================
// vpts_xform: one 4x4 matrix times vector stage group
// Holds one matrix, multiplies in one stage, adds in two, saturates the sums.
// ============================================================================
`default_nettype none

module vpts_xform (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [1:0]        mat_id,
  input  vpts_pkg::xstage_t s_in,
  output vpts_pkg::xstage_t s_out
);
  import vpts_pkg::*;

  localparam int PROD_WIDTH = COORD_WIDTH + ENTRY_WIDTH;
  localparam int TERM_WIDTH = PROD_WIDTH - FRAC_BITS;
  localparam int PAIR_WIDTH = TERM_WIDTH + 1;
  localparam int SUM_WIDTH  = TERM_WIDTH + 2;

  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [TERM_WIDTH-1:0] term_t;
  typedef logic signed [PAIR_WIDTH-1:0] pair_t;

  entry_t  mat_r [4][4];
  prod_t   prod_nxt [4][4];
  prod_t   prod_r [4][4];
  logic    a_valid_r;
  tag_t    a_tag_r;
  pair_t   pair_nxt [4][2];
  pair_t   pair_r [4][2];
  logic    b_valid_r;
  tag_t    b_tag_r;
  xstage_t out_nxt;
  xstage_t out_r;

  function automatic term_t trunc_term(input prod_t p);
    term_t t;
    t = p[PROD_WIDTH-1:FRAC_BITS];
    if (p[PROD_WIDTH-1] && (p[FRAC_BITS-1:0] != '0)) begin
      t = t + term_t'(1);
    end
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (adv && s_in.valid && (s_in.tag.op == OP_LOAD) && (s_in.tag.sel == mat_id)) begin
      mat_r[s_in.tag.row][s_in.tag.col] <= s_in.tag.value;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i][j] = coord_t'(s_in.vec[j]) * mat_r[i][j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pair_nxt[i][0] = pair_t'(trunc_term(prod_r[i][0])) + pair_t'(trunc_term(prod_r[i][1]));
      pair_nxt[i][1] = pair_t'(trunc_term(prod_r[i][2])) + pair_t'(trunc_term(prod_r[i][3]));
    end
  end

  always_comb begin
    logic signed [SUM_WIDTH-1:0] sum;
    out_nxt.valid = b_valid_r;
    out_nxt.tag   = b_tag_r;
    for (int i = 0; i < 4; i++) begin
      sum = SUM_WIDTH'(pair_r[i][0]) + SUM_WIDTH'(pair_r[i][1]);
      out_nxt.vec[i] = sat_coord(SAT_IN_WIDTH'(sum));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= s_in.valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag_r <= s_in.tag;
      prod_r  <= prod_nxt;
      b_tag_r <= a_tag_r;
      pair_r  <= pair_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign s_out = out_r;

endmodule

`default_nettype wire

// File: sv/vpts_divider.sv
// ============================================================================
// vpts_divider: pipelined perspective divide of clip x and y by clip w
// Restoring division, one quotient bit per stage, two lanes sharing w.
// ============================================================================
`default_nettype none

module vpts_divider (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  vpts_pkg::clip_t c_in,
  output vpts_pkg::ndc_t  n_out
);
  import vpts_pkg::*;

  localparam int DIV_STEPS = COORD_WIDTH + FRAC_BITS;
  localparam int REM_WIDTH = COORD_WIDTH;

  typedef logic [COORD_WIDTH-1:0] mag_t;

  typedef struct packed {
    logic                 w_zero;
    logic                 neg_x;
    logic                 neg_y;
    coord_t               byp_x;
    coord_t               byp_y;
    mag_t                 mag_w;
    logic [REM_WIDTH-1:0] rem_x;
    logic [REM_WIDTH-1:0] rem_y;
    logic [DIV_STEPS-1:0] nq_x;
    logic [DIV_STEPS-1:0] nq_y;
  } dstep_t;

  logic [DIV_STEPS:0] dv_r;
  dstep_t             ds_r [DIV_STEPS+1];
  dstep_t             prep_nxt;
  ndc_t               out_nxt;
  ndc_t               out_r;

  function automatic mag_t magnitude(input coord_t v);
    mag_t u;
    u = v;
    return v[COORD_WIDTH-1] ? -u : u;
  endfunction

  always_comb begin
    prep_nxt.w_zero = (c_in.w == '0);
    prep_nxt.neg_x  = c_in.x[COORD_WIDTH-1] ^ c_in.w[COORD_WIDTH-1];
    prep_nxt.neg_y  = c_in.y[COORD_WIDTH-1] ^ c_in.w[COORD_WIDTH-1];
    prep_nxt.byp_x  = c_in.x;
    prep_nxt.byp_y  = c_in.y;
    prep_nxt.mag_w  = magnitude(c_in.w);
    prep_nxt.rem_x  = '0;
    prep_nxt.rem_y  = '0;
    prep_nxt.nq_x   = {magnitude(c_in.x), FRAC_BITS'(0)};
    prep_nxt.nq_y   = {magnitude(c_in.y), FRAC_BITS'(0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= c_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r[0] <= prep_nxt;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    dstep_t step_nxt;

    always_comb begin
      logic [REM_WIDTH:0] tx;
      logic [REM_WIDTH:0] ty;
      logic               gx;
      logic               gy;
      step_nxt = ds_r[k];
      tx = {ds_r[k].rem_x, ds_r[k].nq_x[DIV_STEPS-1]};
      ty = {ds_r[k].rem_y, ds_r[k].nq_y[DIV_STEPS-1]};
      gx = (tx >= {1'b0, ds_r[k].mag_w});
      gy = (ty >= {1'b0, ds_r[k].mag_w});
      step_nxt.rem_x = gx ? REM_WIDTH'(tx - {1'b0, ds_r[k].mag_w}) : tx[REM_WIDTH-1:0];
      step_nxt.rem_y = gy ? REM_WIDTH'(ty - {1'b0, ds_r[k].mag_w}) : ty[REM_WIDTH-1:0];
      step_nxt.nq_x  = {ds_r[k].nq_x[DIV_STEPS-2:0], gx};
      step_nxt.nq_y  = {ds_r[k].nq_y[DIV_STEPS-2:0], gy};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ds_r[k+1] <= step_nxt;
      end
    end
  end

  always_comb begin
    logic signed [DIV_STEPS:0] qx;
    logic signed [DIV_STEPS:0] qy;
    qx = signed'({1'b0, ds_r[DIV_STEPS].nq_x});
    qy = signed'({1'b0, ds_r[DIV_STEPS].nq_y});
    if (ds_r[DIV_STEPS].neg_x) begin
      qx = -qx;
    end
    if (ds_r[DIV_STEPS].neg_y) begin
      qy = -qy;
    end
    out_nxt.valid  = dv_r[DIV_STEPS];
    out_nxt.w_zero = ds_r[DIV_STEPS].w_zero;
    if (ds_r[DIV_STEPS].w_zero) begin
      out_nxt.x = ds_r[DIV_STEPS].byp_x;
      out_nxt.y = ds_r[DIV_STEPS].byp_y;
    end else begin
      out_nxt.x = sat_coord(SAT_IN_WIDTH'(qx));
      out_nxt.y = sat_coord(SAT_IN_WIDTH'(qy));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign n_out = out_r;

endmodule

`default_nettype wire

// File: sv/vpts_viewport.sv
// ============================================================================
// vpts_viewport: maps normalized x and y to screen pixels
// Offset, scale by the screen size, halve toward zero and saturate.
// ============================================================================
`default_nettype none

module vpts_viewport (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [vpts_pkg::DIM_WIDTH-1:0] screen_width,
  input  logic [vpts_pkg::DIM_WIDTH-1:0] screen_height,
  input  vpts_pkg::ndc_t                 n_in,
  output logic                           vp_valid,
  output vpts_pkg::pix_t                 vp_pix
);
  import vpts_pkg::*;

  localparam int A_WIDTH     = COORD_WIDTH + 1;
  localparam int SCALE_WIDTH = DIM_WIDTH + 1;
  localparam int P_WIDTH     = A_WIDTH + SCALE_WIDTH;

  typedef logic signed [A_WIDTH-1:0] ofs_t;
  typedef logic signed [P_WIDTH-1:0] scl_t;
  typedef logic signed [OUT_WIDTH-1:0] out_t;

  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic s1_wz_r, s2_wz_r;
  ofs_t ax_r, ay_r;
  scl_t px_r, py_r;
  pix_t pix_nxt, pix_r;

  function automatic out_t halve_sat(input scl_t p);
    scl_t h;
    out_t r;
    h = (p + scl_t'(p[P_WIDTH-1])) >>> 1;
    if (h > scl_t'({1'b0, {(OUT_WIDTH-1){1'b1}}})) begin
      r = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    end else if (h < scl_t'(signed'({1'b1, {(OUT_WIDTH-1){1'b0}}}))) begin
      r = {1'b1, {(OUT_WIDTH-1){1'b0}}};
    end else begin
      r = out_t'(h);
    end
    return r;
  endfunction

  always_comb begin
    pix_nxt.w_zero = s2_wz_r;
    pix_nxt.sx     = halve_sat(px_r);
    pix_nxt.sy     = halve_sat(py_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= n_in.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_wz_r <= n_in.w_zero;
      ax_r    <= ofs_t'(n_in.x) + ofs_t'(COORD_ONE);
      ay_r    <= ofs_t'(COORD_ONE) - ofs_t'(n_in.y);
      s2_wz_r <= s1_wz_r;
      px_r    <= ax_r * signed'({1'b0, screen_width});
      py_r    <= ay_r * signed'({1'b0, screen_height});
      pix_r   <= pix_nxt;
    end
  end

  assign vp_valid = s3_valid_r;
  assign vp_pix   = pix_r;

endmodule

`default_nettype wire

// File: sv/vertex_project_to_screen.sv
// ============================================================================
// vertex_project_to_screen: fixed-point vertex transform and viewport mapping
// Requests on in_vtx either load one Q16.16 entry of the model, view or
// projection matrix (op clear) or project a point (op set). A point is taken
// through model, view and projection, divided by clip w when w is nonzero,
// and mapped to screen pixels with y flipped; each point gives one result on
// out_pix, loads give none. A load takes effect in program order: it is
// written when it reaches the stage that reads its matrix.
// One request is accepted per cycle while in_vtx.ready is high. The pipeline
// depth is set mainly by the divider's 48 stages, one quotient bit per stage,
// plus three stages per matrix and the viewport.
// cfg_we writes screen_width (index 0) or screen_height (index 1).
// Reset empties the pipeline and restores 640 by 480; matrix entries are
// undefined until loaded. When out_pix stalls, a skid register takes one more
// result, then in_vtx.ready drops and the whole pipeline holds.
// ============================================================================
`default_nettype none

module vertex_project_to_screen (
  input  logic                           clk,
  input  logic                           rst_n,
  vpts_in_if.sink                        in_vtx,
  vpts_out_if.source                     out_pix,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [vpts_pkg::DIM_WIDTH-1:0] cfg_wdata
);
  import vpts_pkg::*;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  logic [DIM_WIDTH-1:0] width_r, height_r;
  logic                 adv;
  xstage_t              v0_nxt, v0_r;
  xstage_t              x0_out, x1_out, x2_out;
  clip_t                clip;
  ndc_t                 ndc;
  logic                 vp_valid;
  pix_t                 vp_pix;
  logic                 push;
  logic                 out_valid_r, skid_valid_r;
  pix_t                 out_data_r, skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_WIDTH'(640);
      height_r <= DIM_WIDTH'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv          = !skid_valid_r;
  assign in_vtx.ready = adv;

  always_comb begin
    v0_nxt.valid     = in_vtx.valid;
    v0_nxt.tag.op    = in_vtx.op;
    v0_nxt.tag.sel   = in_vtx.matrix_select;
    v0_nxt.tag.row   = in_vtx.row_index;
    v0_nxt.tag.col   = in_vtx.col_index;
    v0_nxt.tag.value = in_vtx.entry_value;
    v0_nxt.vec[0]    = coord_t'(in_vtx.point_x);
    v0_nxt.vec[1]    = coord_t'(in_vtx.point_y);
    v0_nxt.vec[2]    = coord_t'(in_vtx.point_z);
    v0_nxt.vec[3]    = COORD_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r.valid <= 1'b0;
    end else if (adv) begin
      v0_r <= v0_nxt;
    end
  end

  vpts_xform u_model (
    .clk(clk), .rst_n(rst_n), .adv(adv), .mat_id(MAT_MODEL), .s_in(v0_r), .s_out(x0_out)
  );

  vpts_xform u_view (
    .clk(clk), .rst_n(rst_n), .adv(adv), .mat_id(MAT_VIEW), .s_in(x0_out), .s_out(x1_out)
  );

  vpts_xform u_proj (
    .clk(clk), .rst_n(rst_n), .adv(adv), .mat_id(MAT_PROJ), .s_in(x1_out), .s_out(x2_out)
  );

  always_comb begin
    clip.valid = x2_out.valid && (x2_out.tag.op == OP_POINT);
    clip.x     = x2_out.vec[0];
    clip.y     = x2_out.vec[1];
    clip.w     = x2_out.vec[3];
  end

  vpts_divider u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .c_in(clip), .n_out(ndc)
  );

  vpts_viewport u_vp (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .screen_width(width_r), .screen_height(height_r),
    .n_in(ndc), .vp_valid(vp_valid), .vp_pix(vp_pix)
  );

  assign push = adv && vp_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_pix.ready) begin
      if (push) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_pix.ready) begin
      if (push) begin
        skid_data_r <= vp_pix;
      end
    end else if (skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else if (push) begin
      out_data_r <= vp_pix;
    end
  end

  assign out_pix.valid      = out_valid_r;
  assign out_pix.screen_x   = out_data_r.sx;
  assign out_pix.screen_y   = out_data_r.sy;
  assign out_pix.w_was_zero = out_data_r.w_zero;

endmodule

`default_nettype wire
